[sv/evr_pkg.sv]
`default_nettype none

package evr_pkg;

   // field widths fixed by the interface
   localparam int SEQ_W       = 48;
   localparam int TIME_W      = 32;
   localparam int LEN_IN_W    = 8;
   localparam int LEN_W       = 4;
   localparam int PAYLOAD_W   = 64;
   localparam int MAXC_W      = 5;
   localparam int PAY_LANES   = PAYLOAD_W / 8;

   // ring geometry (depth must be a power of two: the slot is the low sequence bits)
   localparam int RING_DEPTH    = 16;
   localparam int PAYLOAD_BYTES = 8;
   localparam int MAX_RESULTS   = 16;
   localparam int IDX_W         = $clog2(RING_DEPTH);
   localparam int AVAIL_W       = $clog2(RING_DEPTH + 1);
   localparam int CMP_W         = (AVAIL_W > MAXC_W) ? AVAIL_W : MAXC_W;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // command codes
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // one classified operation: a push with its sequence, or a read with
   // its first sequence and number of events to return
   typedef struct packed {
      logic                 is_read;
      logic [SEQ_W-1:0]     seq;
      logic [TIME_W-1:0]    time_ms;
      logic [LEN_W-1:0]     length;
      logic [PAYLOAD_W-1:0] payload;
      logic [MAXC_W-1:0]    count;
   } op_type;

   // one ring slot
   typedef struct packed {
      logic [SEQ_W-1:0]     seq;
      logic [TIME_W-1:0]    time_ms;
      logic [LEN_W-1:0]     length;
      logic [PAYLOAD_W-1:0] payload;
   } slot_type;

   // queue read side as seen by the back end
   typedef struct packed {
      logic   valid;
      op_type op;
   } queue_out_type;

endpackage

`default_nettype wire

[sv/sequenced_overwrite_event_ring.sv]
// Ring of 16 event slots addressed by sequence number. A push (command 0)
// is taken while busy is low, is dropped while enable is clear, and is
// stored in its slot when the back end pops it from the queue. A read
// (command 1) returns its events one per cycle, each on the rsp_ ports
// for a single cycle marked by rsp_strobe, the final one with rsp_last;
// a read that finds nothing returns one result with rsp_found low. The
// receiver cannot hold results off, so it must take every strobed
// transaction. The back end takes one queued transaction at a time: a
// push is written into its slot, a read walks the slots in order via the
// single slot memory read port, with results passing the holding stage,
// queue, walk state and slot read register. A two-entry queue between the
// classifying front end and the back end lets transactions be taken while
// a read walk is still in progress; busy rises only when both are full.

`default_nettype none

module sequenced_overwrite_event_ring (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           start,
   output logic                          busy,
   input  wire                           req_command,
   input  wire  [evr_pkg::PAYLOAD_W-1:0] req_payload,
   input  wire  [evr_pkg::LEN_IN_W-1:0]  req_length,
   input  wire  [evr_pkg::TIME_W-1:0]    req_time_ms,
   input  wire  [evr_pkg::SEQ_W-1:0]     req_start_seq,
   input  wire  [evr_pkg::MAXC_W-1:0]    req_max_count,
   input  wire                           csr_write_enable,
   input  wire                           csr_write_data,
   output logic                          rsp_strobe,
   output logic                          rsp_found,
   output logic [evr_pkg::SEQ_W-1:0]     rsp_event_seq,
   output logic [evr_pkg::TIME_W-1:0]    rsp_event_time,
   output logic [evr_pkg::LEN_W-1:0]     rsp_event_length,
   output logic [evr_pkg::PAYLOAD_W-1:0] rsp_event_payload,
   output logic                          rsp_last
);

   logic                          queue_full;
   logic                          queue_write;
   evr_pkg::op_type               queue_op;
   evr_pkg::queue_out_type        queue_head;
   logic                          queue_pop;

   // classify and hold incoming transactions
   evr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_payload      (req_payload),
      .req_length       (req_length),
      .req_time_ms      (req_time_ms),
      .req_start_seq    (req_start_seq),
      .req_max_count    (req_max_count),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .queue_full       (queue_full),
      .queue_write      (queue_write),
      .queue_op         (queue_op)
   );

   // decoupling queue
   evr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .write    (queue_write),
      .write_op (queue_op),
      .full     (queue_full),
      .pop      (queue_pop),
      .head     (queue_head)
   );

   // slot memory and read walk
   evr_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (queue_head),
      .pop               (queue_pop),
      .rsp_strobe        (rsp_strobe),
      .rsp_found         (rsp_found),
      .rsp_event_seq     (rsp_event_seq),
      .rsp_event_time    (rsp_event_time),
      .rsp_event_length  (rsp_event_length),
      .rsp_event_payload (rsp_event_payload),
      .rsp_last          (rsp_last)
   );

endmodule

`default_nettype wire

[sv/evr_front.sv]
`default_nettype none

module evr_front (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 start,
   output logic                                busy,
   input  wire                                 req_command,
   input  wire  [evr_pkg::PAYLOAD_W-1:0]       req_payload,
   input  wire  [evr_pkg::LEN_IN_W-1:0]        req_length,
   input  wire  [evr_pkg::TIME_W-1:0]          req_time_ms,
   input  wire  [evr_pkg::SEQ_W-1:0]           req_start_seq,
   input  wire  [evr_pkg::MAXC_W-1:0]          req_max_count,
   input  wire                                 csr_write_enable,
   input  wire                                 csr_write_data,
   input  wire                                 queue_full,
   output logic                                queue_write,
   output evr_pkg::op_type                     queue_op
);

   logic                         enable_ff, enable_in;
   logic [evr_pkg::SEQ_W-1:0]    next_seq_ff, next_seq_in;
   logic [evr_pkg::SEQ_W-1:0]    low_seq_ff, low_seq_in;
   logic                         full_ff, full_in;
   logic                         hold_valid_ff, hold_valid_in;
   evr_pkg::op_type              hold_op_ff, hold_op_in;
   logic [evr_pkg::SEQ_W-1:0]    hold_next_ff, hold_next_in;
   logic                         accept;
   logic                         take;
   logic [evr_pkg::LEN_W-1:0]    len_clamped;
   logic [evr_pkg::PAYLOAD_W-1:0] pay_masked;
   logic [evr_pkg::SEQ_W-1:0]    walk_start;
   logic [evr_pkg::MAXC_W-1:0]   maxc_sat;
   logic [evr_pkg::SEQ_W:0]      seq_diff;
   logic [evr_pkg::AVAIL_W-1:0]  avail;
   logic [evr_pkg::CMP_W-1:0]    avail_ext, maxc_ext;

   // handshake: the holding stage moves on when the queue has room
   assign queue_write = hold_valid_ff && !queue_full;
   assign busy        = hold_valid_ff && queue_full;
   assign accept      = start && !busy;
   assign take        = accept && (req_command == evr_pkg::CMD_READ || enable_ff);

   // enable register
   always_comb begin
      enable_in = csr_write_enable ? csr_write_data : enable_ff;
   end

   // clamp length and clear bytes beyond it
   always_comb begin
      if (req_length > evr_pkg::LEN_IN_W'(evr_pkg::PAYLOAD_BYTES)) begin
         len_clamped = evr_pkg::LEN_W'(evr_pkg::PAYLOAD_BYTES);
      end else begin
         len_clamped = req_length[evr_pkg::LEN_W-1:0];
      end
      for (int b = 0; b < evr_pkg::PAY_LANES; b++) begin
         pay_masked[b*8 +: 8] = (b < int'(len_clamped)) ? req_payload[b*8 +: 8] : 8'h00;
      end
   end

   // read walk begins at the oldest sequence still held, or later
   always_comb begin
      walk_start = (req_start_seq > low_seq_ff) ? req_start_seq : low_seq_ff;
      maxc_sat   = (req_max_count > evr_pkg::MAXC_W'(evr_pkg::MAX_RESULTS)) ?
                   evr_pkg::MAXC_W'(evr_pkg::MAX_RESULTS) : req_max_count;
   end

   // sequence counter and window bottom, advanced by each stored push
   always_comb begin
      next_seq_in = next_seq_ff;
      low_seq_in  = low_seq_ff;
      full_in     = full_ff;
      if (take && req_command == evr_pkg::CMD_PUSH) begin
         next_seq_in = next_seq_ff + evr_pkg::SEQ_W'(1);
         if (next_seq_in == '0) begin
            low_seq_in = '0;
            full_in    = 1'b0;
         end else begin
            low_seq_in = full_ff ? low_seq_ff + evr_pkg::SEQ_W'(1) : '0;
            full_in    = full_ff ||
                         (next_seq_ff == evr_pkg::SEQ_W'(evr_pkg::RING_DEPTH - 1));
         end
      end
   end

   // holding stage: capture the classified transaction
   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_op_in    = hold_op_ff;
      hold_next_in  = hold_next_ff;
      if (queue_write) begin
         hold_valid_in = 1'b0;
      end
      if (take) begin
         hold_valid_in      = 1'b1;
         hold_op_in.is_read = (req_command == evr_pkg::CMD_READ);
         hold_op_in.seq     = (req_command == evr_pkg::CMD_READ) ? walk_start : next_seq_ff;
         hold_op_in.time_ms = req_time_ms;
         hold_op_in.length  = len_clamped;
         hold_op_in.payload = pay_masked;
         hold_op_in.count   = maxc_sat;
         hold_next_in       = next_seq_ff;
      end
   end

   // number of events a read returns: events up to the counter, capped
   always_comb begin
      seq_diff = {1'b0, hold_next_ff} - {1'b0, hold_op_ff.seq};
      if (seq_diff[evr_pkg::SEQ_W] || seq_diff == '0) begin
         avail = '0;
      end else begin
         avail = seq_diff[evr_pkg::AVAIL_W-1:0];
      end
      avail_ext = evr_pkg::CMP_W'(avail);
      maxc_ext  = evr_pkg::CMP_W'(hold_op_ff.count);
      queue_op  = hold_op_ff;
      if (hold_op_ff.is_read) begin
         queue_op.count = (avail_ext < maxc_ext) ? evr_pkg::MAXC_W'(avail_ext) :
                          hold_op_ff.count;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= 1'b0;
         next_seq_ff   <= '0;
         low_seq_ff    <= '0;
         full_ff       <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         enable_ff     <= enable_in;
         next_seq_ff   <= next_seq_in;
         low_seq_ff    <= low_seq_in;
         full_ff       <= full_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      hold_op_ff   <= hold_op_in;
      hold_next_ff <= hold_next_in;
   end

endmodule

`default_nettype wire

[sv/evr_queue.sv]
`default_nettype none

module evr_queue (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    write,
   input  evr_pkg::op_type        write_op,
   output logic                   full,
   input  wire                    pop,
   output evr_pkg::queue_out_type head
);

   evr_pkg::op_type              entry_ff [evr_pkg::QUEUE_DEPTH];
   logic [evr_pkg::QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [evr_pkg::QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [evr_pkg::QCNT_W-1:0]   count_ff, count_in;
   logic                         do_pop;

   assign full       = (count_ff == evr_pkg::QCNT_W'(evr_pkg::QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.op    = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (write) begin
         wr_ptr_in = (wr_ptr_ff == evr_pkg::QPTR_W'(evr_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + evr_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == evr_pkg::QPTR_W'(evr_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + evr_pkg::QPTR_W'(1);
      end
      if (write && !do_pop) begin
         count_in = count_ff + evr_pkg::QCNT_W'(1);
      end else if (do_pop && !write) begin
         count_in = count_ff - evr_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (write) begin
         entry_ff[wr_ptr_ff] <= write_op;
      end
   end

endmodule

`default_nettype wire

[sv/evr_back.sv]
`default_nettype none

module evr_back (
   input  wire                           clock,
   input  wire                           reset,
   input  evr_pkg::queue_out_type        head,
   output logic                          pop,
   output logic                          rsp_strobe,
   output logic                          rsp_found,
   output logic [evr_pkg::SEQ_W-1:0]     rsp_event_seq,
   output logic [evr_pkg::TIME_W-1:0]    rsp_event_time,
   output logic [evr_pkg::LEN_W-1:0]     rsp_event_length,
   output logic [evr_pkg::PAYLOAD_W-1:0] rsp_event_payload,
   output logic                          rsp_last
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WALK = 1'b1;

   evr_pkg::slot_type            slot_mem [evr_pkg::RING_DEPTH];
   evr_pkg::slot_type            rd_slot_ff;
   evr_pkg::slot_type            wr_slot;
   logic                         state_ff, state_in;
   logic [evr_pkg::IDX_W-1:0]    cur_idx_ff, cur_idx_in;
   logic [evr_pkg::MAXC_W-1:0]   remain_ff, remain_in;
   logic                         strobe_ff, strobe_in;
   logic                         found_ff, found_in;
   logic                         last_ff, last_in;
   logic                         wr_en;
   logic [evr_pkg::IDX_W-1:0]    wr_idx;
   logic                         rd_en;

   assign pop = (state_ff == ST_IDLE) && head.valid;

   // slot write data for a push
   always_comb begin
      wr_slot.seq     = head.op.seq;
      wr_slot.time_ms = head.op.time_ms;
      wr_slot.length  = head.op.length;
      wr_slot.payload = head.op.payload;
      wr_idx          = head.op.seq[evr_pkg::IDX_W-1:0];
      wr_en           = pop && !head.op.is_read;
   end

   // sequencer: a push is written when popped, reads walk one slot a cycle;
   // inside the window every slot still holds its own sequence number
   always_comb begin
      state_in   = state_ff;
      cur_idx_in = cur_idx_ff;
      remain_in  = remain_ff;
      strobe_in  = 1'b0;
      found_in   = found_ff;
      last_in    = last_ff;
      rd_en      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (pop && head.op.is_read) begin
               if (head.op.count == '0) begin
                  strobe_in = 1'b1;
                  found_in  = 1'b0;
                  last_in   = 1'b1;
               end else begin
                  state_in   = ST_WALK;
                  cur_idx_in = head.op.seq[evr_pkg::IDX_W-1:0];
                  remain_in  = head.op.count;
               end
            end
         end
         ST_WALK: begin
            rd_en      = 1'b1;
            strobe_in  = 1'b1;
            found_in   = 1'b1;
            last_in    = (remain_ff == evr_pkg::MAXC_W'(1));
            cur_idx_in = cur_idx_ff + evr_pkg::IDX_W'(1);
            remain_in  = remain_ff - evr_pkg::MAXC_W'(1);
            if (remain_ff == evr_pkg::MAXC_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_idx_ff <= cur_idx_in;
      remain_ff  <= remain_in;
      found_ff   <= found_in;
      last_ff    <= last_in;
   end

   // slot memory with registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_idx] <= wr_slot;
      end
      if (rd_en) begin
         rd_slot_ff <= slot_mem[cur_idx_ff];
      end
   end

   // result transaction; an empty read shows zero fields
   assign rsp_strobe        = strobe_ff;
   assign rsp_found         = found_ff;
   assign rsp_last          = last_ff;
   assign rsp_event_seq     = found_ff ? rd_slot_ff.seq     : '0;
   assign rsp_event_time    = found_ff ? rd_slot_ff.time_ms : '0;
   assign rsp_event_length  = found_ff ? rd_slot_ff.length  : '0;
   assign rsp_event_payload = found_ff ? rd_slot_ff.payload : '0;

endmodule

`default_nettype wire
